// ===== design/stst_pkg.sv =====
// Shared types and constants for the stroke straightness test.
// Used by the controller, the datapath and the top level; no dependencies.
package stst_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int COORD_BITS_DEF = 16;
  localparam int IN_COORD_W     = 16;
  localparam int THR_W          = 16;
  localparam int MINP_W         = 13;
  localparam int TOTAL_W        = 13;
  localparam int VERDICT_W      = 2;
  localparam logic [THR_W-1:0]  THR_RESET  = 16'd6554;
  localparam logic [MINP_W-1:0] MINP_RESET = 13'd8;

  typedef enum logic [VERDICT_W-1:0] {
    V_STRAIGHT = 2'd0,
    V_BENT     = 2'd1,
    V_SHORT    = 2'd2,
    V_OVERFLOW = 2'd3
  } verdict_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CAPTURE,
    DP_SQ_XX,
    DP_SQ_YY,
    DP_SQ_XY,
    DP_LOAD,
    DP_RUN,
    DP_STORE,
    DP_CLEAR
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_NXX,
    ST_SX2,
    ST_NYY,
    ST_SY2,
    ST_NXY,
    ST_SXSY,
    ST_XXYY,
    ST_XY2,
    ST_LHS,
    ST_T2,
    ST_RHS
  } step_t;

  typedef struct packed {
    dp_op_t op;
    step_t  step;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic ovf;
    logic short_pts;
    logic t_zero;
    logic less;
  } dp_stat_t;

endpackage

// ===== design/stst_datapath.sv =====
// Datapath: point accumulators, scatter terms and a shared shift-add multiplier.
// Depends on stst_pkg for command and status types.
module stst_datapath #(
  parameter int MAX_POINTS = stst_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = stst_pkg::COORD_BITS_DEF,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stst_pkg::dp_cmd_t                   cmd,
  input  logic signed [stst_pkg::IN_COORD_W-1:0] in_x,
  input  logic signed [stst_pkg::IN_COORD_W-1:0] in_y,
  input  logic [stst_pkg::THR_W-1:0]          thr,
  input  logic [stst_pkg::MINP_W-1:0]         min_pts,
  output stst_pkg::dp_stat_t                  st,
  output logic [CNT_W-1:0]                    count
);
  import stst_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int SUM_W = CW + CNT_W;
  localparam int SQ_W  = 2 * CW + CNT_W;
  localparam int SC_W  = CNT_W + SQ_W + 1;
  localparam int MB_W  = (SC_W + 1 > 34) ? SC_W + 1 : 34;
  localparam int PW    = 2 * SC_W + 36;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  logic [CW-1:0] xc, yc;
  for (genvar i = 0; i < CW; i++) begin : g_coord
    if (i < IN_COORD_W) begin : g_in
      assign xc[i] = in_x[i];
      assign yc[i] = in_y[i];
    end else begin : g_pad
      assign xc[i] = 1'b0;
      assign yc[i] = 1'b0;
    end
  end

  logic [CNT_W-1:0]        cnt_r;
  logic                    ovf_r, take_r;
  logic signed [CW-1:0]    x_r, y_r;
  logic signed [SUM_W-1:0] sx_r, sy_r;
  logic [SQ_W-1:0]         sxx_r, syy_r;
  logic signed [SQ_W-1:0]  sxy_r;
  logic [SC_W-1:0]         cxx_r, cyy_r, cxy_r;
  logic [SC_W:0]           t_r;
  logic [PW-1:0]           tmp_r, t2_r, a_r, prod_r;
  logic [MB_W-1:0]         b_r;
  logic                    less_r;

  logic signed [CW-1:0]   sq_a, sq_b;
  logic signed [2*CW-1:0] sq_p;
  logic [SUM_W-1:0]       mag_x, mag_y;
  logic [SQ_W-1:0]        mag_xy;
  logic [16:0]            bb;
  logic [33:0]            bb2;
  logic [PW-1:0]          a_nxt, comb_xy;
  logic [MB_W-1:0]        b_nxt;
  logic [CNT_W+MINP_W-1:0] cnt_ext, min_ext;

  always_comb begin
    sq_a = x_r;
    sq_b = x_r;
    case (cmd.op)
      DP_SQ_YY: begin
        sq_a = y_r;
        sq_b = y_r;
      end
      DP_SQ_XY: begin
        sq_a = x_r;
        sq_b = y_r;
      end
      default: begin
        sq_a = x_r;
        sq_b = x_r;
      end
    endcase
  end
  assign sq_p = sq_a * sq_b;

  assign mag_x  = sx_r[SUM_W-1] ? SUM_W'(-sx_r) : SUM_W'(sx_r);
  assign mag_y  = sy_r[SUM_W-1] ? SUM_W'(-sy_r) : SUM_W'(sy_r);
  assign mag_xy = sxy_r[SQ_W-1] ? SQ_W'(-sxy_r) : SQ_W'(sxy_r);
  assign bb     = {1'b1, thr};
  assign bb2    = bb * bb;

  always_comb begin
    a_nxt = '0;
    b_nxt = '0;
    unique case (cmd.step)
      ST_NXX: begin
        a_nxt = PW'(sxx_r);
        b_nxt = MB_W'(cnt_r);
      end
      ST_SX2: begin
        a_nxt = PW'(mag_x);
        b_nxt = MB_W'(mag_x);
      end
      ST_NYY: begin
        a_nxt = PW'(syy_r);
        b_nxt = MB_W'(cnt_r);
      end
      ST_SY2: begin
        a_nxt = PW'(mag_y);
        b_nxt = MB_W'(mag_y);
      end
      ST_NXY: begin
        a_nxt = PW'(mag_xy);
        b_nxt = MB_W'(cnt_r);
      end
      ST_SXSY: begin
        a_nxt = PW'(mag_x);
        b_nxt = MB_W'(mag_y);
      end
      ST_XXYY: begin
        a_nxt = PW'(cxx_r);
        b_nxt = MB_W'(cyy_r);
      end
      ST_XY2: begin
        a_nxt = PW'(cxy_r);
        b_nxt = MB_W'(cxy_r);
      end
      ST_LHS: begin
        a_nxt = tmp_r;
        b_nxt = MB_W'(bb2);
      end
      ST_T2: begin
        a_nxt = PW'(t_r);
        b_nxt = MB_W'(t_r);
      end
      ST_RHS: begin
        a_nxt = t2_r;
        b_nxt = MB_W'({thr, 16'b0});
      end
      default: begin
        a_nxt = '0;
        b_nxt = '0;
      end
    endcase
  end

  always_comb begin
    if (sxy_r[SQ_W-1] == (sx_r[SUM_W-1] ^ sy_r[SUM_W-1])) begin
      comb_xy = (tmp_r >= prod_r) ? tmp_r - prod_r : prod_r - tmp_r;
    end else begin
      comb_xy = tmp_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      take_r <= 1'b0;
      sx_r   <= '0;
      sy_r   <= '0;
      sxx_r  <= '0;
      syy_r  <= '0;
      sxy_r  <= '0;
      b_r    <= '0;
    end else begin
      case (cmd.op)
        DP_CAPTURE: begin
          x_r <= xc;
          y_r <= yc;
          if (cnt_r == CNT_MAX) begin
            ovf_r  <= 1'b1;
            take_r <= 1'b0;
          end else begin
            take_r <= 1'b1;
            cnt_r  <= cnt_r + 1'b1;
            sx_r   <= sx_r + {{CNT_W{xc[CW-1]}}, xc};
            sy_r   <= sy_r + {{CNT_W{yc[CW-1]}}, yc};
          end
        end
        DP_SQ_XX: if (take_r) sxx_r <= sxx_r + SQ_W'(unsigned'(sq_p));
        DP_SQ_YY: if (take_r) syy_r <= syy_r + SQ_W'(unsigned'(sq_p));
        DP_SQ_XY: if (take_r) sxy_r <= sxy_r + {{CNT_W{sq_p[2*CW-1]}}, sq_p};
        DP_LOAD: begin
          a_r    <= a_nxt;
          b_r    <= b_nxt;
          prod_r <= '0;
        end
        DP_RUN: begin
          if (b_r != '0) begin
            if (b_r[0]) prod_r <= prod_r + a_r;
            a_r <= {a_r[PW-2:0], 1'b0};
            b_r <= b_r >> 1;
          end
        end
        DP_STORE: begin
          unique case (cmd.step)
            ST_NXX, ST_NYY, ST_NXY, ST_XXYY, ST_LHS: tmp_r <= prod_r;
            ST_SX2:  cxx_r <= SC_W'(tmp_r - prod_r);
            ST_SY2:  cyy_r <= SC_W'(tmp_r - prod_r);
            ST_SXSY: begin
              cxy_r <= SC_W'(comb_xy);
              t_r   <= {1'b0, cxx_r} + {1'b0, cyy_r};
            end
            ST_XY2:  tmp_r  <= tmp_r - prod_r;
            ST_T2:   t2_r   <= prod_r;
            ST_RHS:  less_r <= (tmp_r < prod_r);
            default: less_r <= less_r;
          endcase
        end
        DP_CLEAR: begin
          cnt_r  <= '0;
          ovf_r  <= 1'b0;
          take_r <= 1'b0;
          sx_r   <= '0;
          sy_r   <= '0;
          sxx_r  <= '0;
          syy_r  <= '0;
          sxy_r  <= '0;
        end
        default: take_r <= take_r;
      endcase
    end
  end

  assign cnt_ext = {{MINP_W{1'b0}}, cnt_r};
  assign min_ext = {{CNT_W{1'b0}}, min_pts};

  assign st.busy      = (b_r != '0);
  assign st.ovf       = ovf_r;
  assign st.short_pts = (cnt_ext < min_ext);
  assign st.t_zero    = (t_r == '0);
  assign st.less      = less_r;
  assign count        = cnt_r;

endmodule

// ===== design/stst_ctrl.sv =====
// Controller: sequences accumulation, the straightness test and the result beat.
// Depends on stst_pkg for command, status and verdict types.
module stst_ctrl #(
  parameter int CNT_W = 13
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [stst_pkg::VERDICT_W-1:0]     out_verdict,
  output logic [stst_pkg::TOTAL_W-1:0]       out_total,
  output stst_pkg::dp_cmd_t                  cmd,
  input  stst_pkg::dp_stat_t                 st,
  input  logic [CNT_W-1:0]                   count
);
  import stst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQXX, S_SQYY, S_SQXY, S_DECIDE, S_LOAD, S_RUN, S_STORE,
    S_TCHK, S_FIN, S_EMIT
  } state_t;

  state_t   state_r;
  step_t    step_r;
  logic     last_r;
  verdict_t pend_r;
  logic     out_valid_r;
  verdict_t verdict_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CNT_W+TOTAL_W-1:0] count_ext;

  assign count_ext = {{TOTAL_W{1'b0}}, count};
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd.step = step_r;
    unique case (state_r)
      S_IDLE:  cmd.op = in_tvalid ? DP_CAPTURE : DP_IDLE;
      S_SQXX:  cmd.op = DP_SQ_XX;
      S_SQYY:  cmd.op = DP_SQ_YY;
      S_SQXY:  cmd.op = DP_SQ_XY;
      S_LOAD:  cmd.op = DP_LOAD;
      S_RUN:   cmd.op = DP_RUN;
      S_STORE: cmd.op = DP_STORE;
      S_EMIT:  cmd.op = (!out_valid_r || out_tready) ? DP_CLEAR : DP_IDLE;
      default: cmd.op = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_NXX;
      last_r      <= 1'b0;
      pend_r      <= V_STRAIGHT;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            last_r  <= in_tlast;
            state_r <= S_SQXX;
          end
        end
        S_SQXX: state_r <= S_SQYY;
        S_SQYY: state_r <= S_SQXY;
        S_SQXY: state_r <= last_r ? S_DECIDE : S_IDLE;
        S_DECIDE: begin
          if (st.ovf) begin
            pend_r  <= V_OVERFLOW;
            state_r <= S_EMIT;
          end else if (st.short_pts) begin
            pend_r  <= V_SHORT;
            state_r <= S_EMIT;
          end else begin
            step_r  <= ST_NXX;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: state_r <= S_RUN;
        S_RUN:  if (!st.busy) state_r <= S_STORE;
        S_STORE: begin
          unique case (step_r)
            ST_SXSY: state_r <= S_TCHK;
            ST_RHS:  state_r <= S_FIN;
            default: begin
              step_r  <= step_t'(step_r + 1'b1);
              state_r <= S_LOAD;
            end
          endcase
        end
        S_TCHK: begin
          if (st.t_zero) begin
            pend_r  <= V_BENT;
            state_r <= S_EMIT;
          end else begin
            step_r  <= ST_XXYY;
            state_r <= S_LOAD;
          end
        end
        S_FIN: begin
          pend_r  <= st.less ? V_STRAIGHT : V_BENT;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            verdict_r   <= pend_r;
            total_r     <= count_ext[TOTAL_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_verdict = verdict_r;
  assign out_total   = total_r;

`ifndef NO_ASSERTIONS
  a_ready_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !st.busy) else $error("point accepted while multiplier busy");
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_CLEAR |=> (count == '0 && !st.ovf))
    else $error("accumulators not cleared after result");
  a_capture_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == DP_CAPTURE |=> state_r == S_SQXX)
    else $error("capture not followed by square accumulation");
`endif

endmodule

// ===== design/stroke_straightness_test_core.sv =====
// Stroke straightness test: each point is accepted, then gets three square updates before the next.
// The last point then runs up to eleven shift-add multiplies in the shared datapath multiplier,
// each a load, a run that shifts out its second operand bit by bit, and a store.
// The result beat waits in an output register while new points are accepted.
// Synchronous active-low reset clears the accumulators and restores register defaults.
module stroke_straightness_test_core #(
  parameter int MAX_POINTS = stst_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = stst_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_coord [15:0], y_coord [31:16]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // verdict [1:0], point_total [14:2], zero [15]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import stst_pkg::*;

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [THR_W-1:0]   thr_r;
  logic [MINP_W-1:0]  minp_r;
  dp_cmd_t            cmd;
  dp_stat_t           st;
  logic [CNT_W-1:0]   count;
  logic [VERDICT_W-1:0] verdict;
  logic [TOTAL_W-1:0] total;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      minp_r <= MINP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2]) minp_r <= cfg_pwdata[MINP_W-1:0];
      else              thr_r  <= cfg_pwdata[THR_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? {{(32-MINP_W){1'b0}}, minp_r}
                                   : {{(32-THR_W){1'b0}}, thr_r};

  stst_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_x    (in_tdata[15:0]),
    .in_y    (in_tdata[31:16]),
    .thr     (thr_r),
    .min_pts (minp_r),
    .st      (st),
    .count   (count)
  );

  stst_ctrl #(
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_verdict (verdict),
    .out_total   (total),
    .cmd         (cmd),
    .st          (st),
    .count       (count)
  );

  assign out_tdata = {1'b0, total, verdict};

endmodule

// ===== tb/tb_stroke_straightness_test_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for stroke_straightness_test_core: strokes go in over the point
// stream, verdicts are predicted from exact wide sums and checked beat by beat.
// Depends on stst_pkg and the core only.
module tb_stroke_straightness_test_core;
  import stst_pkg::*;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } point_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [12:0] total;
  } verdict_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // x_coord [15:0], y_coord [31:16]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // verdict [1:0], point_total [14:2], zero [15]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam logic [2:0] ADDR_THRESHOLD  = 3'd0;
  localparam logic [2:0] ADDR_MIN_POINTS = 3'd4;

  point_t        pending_points[$];
  verdict_beat_t expected_verdicts[$];
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  logic [15:0] model_threshold;
  logic [12:0] model_min_points;
  int          stroke_count;
  longint      acc_x, acc_y, acc_xx, acc_yy, acc_xy;
  logic        stroke_overflowed;

  stroke_straightness_test_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
    errors++;
  endtask

  function automatic verdict_t straightness_verdict();
    logic signed [255:0] n, sxx, syy, sxy, tr, det, bb, lhs, rhs;
    n = stroke_count;
    sxx = n * acc_xx - acc_x * acc_x;
    syy = n * acc_yy - acc_y * acc_y;
    sxy = n * acc_xy - acc_x * acc_y;
    tr = sxx + syy;
    if (tr == 0) return V_BENT;
    det = sxx * syy - sxy * sxy;
    bb = 65536 + model_threshold;
    lhs = bb * bb * det;
    rhs = (model_threshold * 256'sd65536) * tr * tr;
    return (lhs < rhs) ? V_STRAIGHT : V_BENT;
  endfunction

  function automatic void take_point(input point_t p);
    longint x, y;
    verdict_beat_t r;
    x = longint'($signed(p.x));
    y = longint'($signed(p.y));
    if (stroke_count < MAX_POINTS_DEF) begin
      stroke_count++;
      acc_x += x;
      acc_y += y;
      acc_xx += x * x;
      acc_yy += y * y;
      acc_xy += x * y;
    end else begin
      stroke_overflowed = 1'b1;
    end
    if (!p.last) return;
    if (stroke_overflowed) r.verdict = V_OVERFLOW;
    else if (stroke_count < model_min_points) r.verdict = V_SHORT;
    else r.verdict = straightness_verdict();
    r.total = stroke_count[12:0];
    expected_verdicts.push_back(r);
    stroke_count = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    stroke_overflowed = 1'b0;
  endfunction

  // Point driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) take_point('{in_tdata[15:0], in_tdata[31:16], in_tlast});
      if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        point_t p;
        p = pending_points.pop_front();
        in_tdata <= {p.y, p.x};
        in_tlast <= p.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Verdict monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected verdict beat", out_tdata, -1);
        end else begin
          verdict_beat_t e;
          e = expected_verdicts.pop_front();
          if (out_tdata[1:0] !== e.verdict) report_mismatch("verdict", out_tdata[1:0], e.verdict);
          if (out_tdata[14:2] !== e.total) report_mismatch("point_total", out_tdata[14:2], e.total);
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_THRESHOLD) model_threshold = value[15:0];
    else model_min_points = value[12:0];
  endtask

  task automatic add_point(input int x, input int y, input bit last);
    pending_points.push_back('{x[15:0], y[15:0], last});
  endtask

  // Mostly noisy lines, sometimes repeated points or full-range noise.
  task automatic add_random_stroke(output int len);
    int kind, x0, y0, dx, dy, noise;
    kind = $urandom_range(9);
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
    x0 = $urandom_range(4000) - 2000;
    y0 = $urandom_range(4000) - 2000;
    dx = $urandom_range(600) - 300;
    dy = $urandom_range(600) - 300;
    noise = (1 << $urandom_range(9)) - 1;
    for (int i = 0; i < len; i++) begin
      if (kind == 0)
        add_point($urandom, $urandom, i == len - 1);
      else if (kind == 1)
        add_point(x0, y0, i == len - 1);
      else
        add_point(x0 + i * dx + $urandom_range(noise) - noise / 2,
                  y0 + i * dy + $urandom_range(noise) - noise / 2, i == len - 1);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int point_budget);
    int used, len;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    used = 0;
    while (used < point_budget) begin
      add_random_stroke(len);
      used += len;
    end
    while (pending_points.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (900) @(posedge clk);
  endtask

  initial begin
    model_threshold = THR_RESET;
    model_min_points = MINP_RESET;
    stroke_count = 0;
    acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
    stroke_overflowed = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strokes at reset settings.
    add_point(-32768, -32768, 1'b1);
    add_point(32767, 32767, 1'b0);
    add_point(-32768, 32767, 1'b0);
    add_point(32767, -32768, 1'b1);
    for (int i = 0; i < 8; i++) add_point(100 * i, 50 * i, i == 7);
    for (int i = 0; i < 8; i++) add_point(-7, 9, i == 7);
    run_phase(0, 0, 0);

    write_register(ADDR_MIN_POINTS, 2);
    add_point(5, 5, 1'b1);
    add_point(0, 0, 1'b0);
    add_point(0, 0, 1'b1);
    add_point(-32768, 0, 1'b0);
    add_point(32767, 0, 1'b1);
    run_phase(0, 0, 0);
    write_register(ADDR_THRESHOLD, 0);
    run_phase(0, 0, 150);

    write_register(ADDR_THRESHOLD, 65535);
    run_phase(74, 0, 200);
    write_register(ADDR_THRESHOLD, $urandom_range(65535));
    write_register(ADDR_MIN_POINTS, 4096);
    add_point(1, 1, 1'b1);
    run_phase(0, 0, 0);
    write_register(ADDR_MIN_POINTS, $urandom_range(2, 6));
    run_phase(0, 74, 200);
    write_register(ADDR_MIN_POINTS, 5000);
    run_phase(12, 12, 60);
    write_register(ADDR_THRESHOLD, 32768);
    write_register(ADDR_MIN_POINTS, 3);
    run_phase(12, 12, 150);
    write_register(ADDR_THRESHOLD, $urandom_range(1, 20000));
    run_phase(0, 0, 100);

    if (errors == 0) $display("stroke_straightness_test_core verification clean");
    else $display("stroke_straightness_test_core verification failed");
    $finish;
  end

  initial begin
    #50ms;
    $display("stroke_straightness_test_core verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/stst_pkg.sv
design/stst_datapath.sv
design/stst_ctrl.sv
design/stroke_straightness_test_core.sv
tb/tb_stroke_straightness_test_core.sv
